// ----- rtl/bpb_pkg.sv -----
// bpb_pkg: shared types, register codes and the divide-by-255 helper for the brush pixel blend
`default_nettype none
package bpb_pkg;

   // reciprocal of 255 in Q23, exact for dividends up to 66051
   localparam logic [31:0] RECIP_255   = 32'd32897;
   localparam int          RECIP_SHIFT = 23;
   localparam logic [8:0]  ALPHA_FULL  = 9'd256;
   localparam logic [7:0]  TONE_MAX    = 8'd255;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_ALPHA_Q8       = 3'd0,
      REG_PAINT_RED      = 3'd1,
      REG_PAINT_GREEN    = 3'd2,
      REG_PAINT_BLUE     = 3'd3,
      REG_COLOUR_PRESENT = 3'd4,
      REG_TOOL_MODE      = 3'd5,
      REG_BLEND_SELECT   = 3'd6,
      REG_SINGLE_CHANNEL = 3'd7
   } reg_index_type;

   // tool codes
   localparam logic [1:0] TOOL_PAINT  = 2'd0;
   localparam logic [1:0] TOOL_ERASE  = 2'd1;
   localparam logic [1:0] TOOL_SMUDGE = 2'd2;

   // blend codes
   localparam logic [1:0] BLEND_NORMAL   = 2'd0;
   localparam logic [1:0] BLEND_MULTIPLY = 2'd1;
   localparam logic [1:0] BLEND_SCREEN   = 2'd2;

   // where each channel's tone comes from
   typedef enum logic [2:0] {
      TONE_ZERO     = 3'd0,
      TONE_FULL     = 3'd1,
      TONE_COLOUR   = 3'd2,
      TONE_MULTIPLY = 3'd3,
      TONE_SCREEN   = 3'd4
   } tone_kind_type;

   typedef struct packed {
      logic [8:0] alpha_q8;
      logic [7:0] paint_red;
      logic [7:0] paint_green;
      logic [7:0] paint_blue;
      logic       colour_present;
      logic [1:0] tool_mode;
      logic [1:0] blend_select;
      logic       single_channel;
   } csr_type;

   typedef struct packed {
      logic [2:0] index;
      logic [8:0] value;
   } csr_word_type;

   typedef struct packed {
      logic [7:0] coverage;
      logic [7:0] old_c0;
      logic [7:0] old_c1;
      logic [7:0] old_c2;
   } req_word_type;

   typedef struct packed {
      logic [7:0] new_c0;
      logic [7:0] new_c1;
      logic [7:0] new_c2;
      logic       changed;
   } rsp_word_type;

   // per-stage load enables, stage one in bit zero
   typedef struct packed {
      logic [3:0] load;
   } stage_ctrl_type;

   // floor(x / 255) for x up to 65535
   function automatic logic [8:0] div255(input logic [15:0] x);
      logic [31:0] scaled;
      begin
         scaled = 32'(x) * RECIP_255;
         div255 = scaled[31:RECIP_SHIFT];
      end
   endfunction

   // tone source from tool, blend mode and target format
   function automatic tone_kind_type tone_kind(input csr_type c);
      tone_kind_type k;
      begin
         if (c.tool_mode == TOOL_ERASE) begin
            k = TONE_ZERO;
         end else if (c.tool_mode == TOOL_SMUDGE || c.single_channel || !c.colour_present) begin
            k = TONE_FULL;
         end else if (c.blend_select == BLEND_MULTIPLY) begin
            k = TONE_MULTIPLY;
         end else if (c.blend_select == BLEND_SCREEN) begin
            k = TONE_SCREEN;
         end else begin
            k = TONE_COLOUR;
         end
         tone_kind = k;
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/bpb_stream_if.sv -----
// bpb_stream_if: valid/ready channel carrying one word of a given type
`default_nettype none
interface bpb_stream_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/bpb_csr.sv -----
// bpb_csr: configuration register file written through the csr channel
`default_nettype none
module bpb_csr (
   input  wire logic       clock,
   input  wire logic       reset,
   bpb_stream_if.sink      csr_chan,
   output bpb_pkg::csr_type csr
);

   // register values after reset
   localparam bpb_pkg::csr_type CSR_RESET = '{
      alpha_q8:       bpb_pkg::ALPHA_FULL,
      paint_red:      8'd0,
      paint_green:    8'd0,
      paint_blue:     8'd0,
      colour_present: 1'b1,
      tool_mode:      bpb_pkg::TOOL_PAINT,
      blend_select:   bpb_pkg::BLEND_NORMAL,
      single_channel: 1'b0
   };

   bpb_pkg::csr_type csr_ff;
   bpb_pkg::csr_type csr_in;
   bpb_pkg::csr_word_type word;

   assign csr_chan.ready = 1'b1;
   assign word = csr_chan.data;
   assign csr = csr_ff;

   // register write decode
   always_comb begin
      csr_in = csr_ff;
      if (csr_chan.valid) begin
         case (bpb_pkg::reg_index_type'(word.index))
            bpb_pkg::REG_ALPHA_Q8:       csr_in.alpha_q8       = word.value;
            bpb_pkg::REG_PAINT_RED:      csr_in.paint_red      = word.value[7:0];
            bpb_pkg::REG_PAINT_GREEN:    csr_in.paint_green    = word.value[7:0];
            bpb_pkg::REG_PAINT_BLUE:     csr_in.paint_blue     = word.value[7:0];
            bpb_pkg::REG_COLOUR_PRESENT: csr_in.colour_present = word.value[0];
            bpb_pkg::REG_TOOL_MODE:      csr_in.tool_mode      = word.value[1:0];
            bpb_pkg::REG_BLEND_SELECT:   csr_in.blend_select   = word.value[1:0];
            bpb_pkg::REG_SINGLE_CHANNEL: csr_in.single_channel = word.value[0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/bpb_ctrl.sv -----
// bpb_ctrl: valid bits and load enables of the four pipeline stages
`default_nettype none
module bpb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output bpb_pkg::stage_ctrl_type stage_ctrl
);

   logic [3:0] valid_ff;
   logic [3:0] valid_in;
   logic [3:0] load;

   // a stage loads when empty or when the one after it moves
   always_comb begin
      load[3] = !valid_ff[3] || out_ready;
      for (int k = 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < 4; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready        = load[0];
   assign out_valid       = valid_ff[3];
   assign stage_ctrl.load = load;

`ifndef NO_ASSERTIONS
   // a waiting result word is never dropped
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !out_ready) |=> valid_ff[3])
      else $error("result word lost while stalled");

   // full pipeline with a stalled output takes nothing new
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !out_ready) |-> !in_ready)
      else $error("input taken while pipeline full");

   // an accepted word lands in stage one
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> valid_ff[0])
      else $error("accepted word not in stage one");
`endif

endmodule
`default_nettype wire

// ----- rtl/bpb_weight.sv -----
// bpb_weight: Q1.16 blend weight from coverage and strength, plus the changed flag
`default_nettype none
module bpb_weight (
   input  wire logic                   clock,
   input  wire bpb_pkg::stage_ctrl_type stage_ctrl,
   input  wire logic [7:0]             coverage,
   input  wire logic [8:0]             alpha_q8,
   output logic [16:0]                 weight,
   output logic                        changed
);

   logic [8:0]  alpha_sat;
   logic [15:0] prod_ff;
   logic [15:0] prod_in;
   logic [16:0] weight_ff;
   logic [16:0] weight_in;
   logic [3:0]  cov_nz_ff;
   logic [3:0]  cov_nz_in;

   // stage one: coverage times saturated strength
   always_comb begin
      alpha_sat = (alpha_q8 > bpb_pkg::ALPHA_FULL) ? bpb_pkg::ALPHA_FULL : alpha_q8;
      prod_in   = 16'(17'(coverage) * 17'(alpha_sat));
   end

   // stage two: p * 256 / 255 written as p + p / 255
   assign weight_in = 17'(prod_ff) + 17'(bpb_pkg::div255(prod_ff));

   // nonzero coverage flag travelling with its word
   always_comb begin
      cov_nz_in[0] = stage_ctrl.load[0] ? (coverage != 8'd0) : cov_nz_ff[0];
      for (int k = 1; k < 4; k++) begin
         cov_nz_in[k] = stage_ctrl.load[k] ? cov_nz_ff[k-1] : cov_nz_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ctrl.load[0]) begin
         prod_ff <= prod_in;
      end
      if (stage_ctrl.load[1]) begin
         weight_ff <= weight_in;
      end
      cov_nz_ff <= cov_nz_in;
   end

   assign weight  = weight_ff;
   assign changed = cov_nz_ff[3];

endmodule
`default_nettype wire

// ----- rtl/bpb_lane.sv -----
// bpb_lane: tone and mix datapath of one colour channel, four stages
`default_nettype none
module bpb_lane (
   input  wire logic                   clock,
   input  wire bpb_pkg::stage_ctrl_type stage_ctrl,
   input  wire logic [7:0]             old_value,
   input  wire logic [7:0]             colour,
   input  wire bpb_pkg::tone_kind_type kind,
   input  wire logic                   lane_on,
   input  wire logic [16:0]            weight,
   output logic [7:0]                  new_value
);

   // stage one registers
   logic [7:0]             old1_ff;
   logic [7:0]             colour1_ff;
   bpb_pkg::tone_kind_type kind1_ff;
   logic                   on1_ff;
   logic [15:0]            prod1_ff;
   logic [15:0]            prod1_in;
   logic [7:0]             mul_a;
   logic [7:0]             mul_b;
   // stage two registers
   logic [7:0]             old2_ff;
   logic                   on2_ff;
   logic [7:0]             tone2_ff;
   logic [7:0]             tone2_in;
   logic [8:0]             quot_full;
   logic [7:0]             quot;
   // stage three registers
   logic [7:0]             old3_ff;
   logic signed [25:0]     mix3_ff;
   logic signed [25:0]     mix3_in;
   logic signed [8:0]      diff;
   logic [16:0]            weight_eff;
   // stage four
   logic [7:0]             res_ff;
   logic [7:0]             res_in;
   logic [9:0]             sum;

   // stage one: product for multiply or screen
   always_comb begin
      if (kind == bpb_pkg::TONE_SCREEN) begin
         mul_a = bpb_pkg::TONE_MAX - old_value;
         mul_b = bpb_pkg::TONE_MAX - colour;
      end else begin
         mul_a = old_value;
         mul_b = colour;
      end
      prod1_in = 16'(mul_a) * 16'(mul_b);
   end

   // stage two: divide by 255 and pick the tone
   always_comb begin
      quot_full = bpb_pkg::div255(prod1_ff);
      quot      = quot_full[7:0];
      case (kind1_ff)
         bpb_pkg::TONE_ZERO:     tone2_in = 8'd0;
         bpb_pkg::TONE_FULL:     tone2_in = bpb_pkg::TONE_MAX;
         bpb_pkg::TONE_COLOUR:   tone2_in = colour1_ff;
         bpb_pkg::TONE_MULTIPLY: tone2_in = quot;
         bpb_pkg::TONE_SCREEN:   tone2_in = bpb_pkg::TONE_MAX - quot;
         default:                tone2_in = colour1_ff;
      endcase
   end

   // stage three: (tone - old) * weight, unused lanes get no weight
   always_comb begin
      diff       = $signed({1'b0, tone2_ff}) - $signed({1'b0, old2_ff});
      weight_eff = on2_ff ? weight : 17'd0;
      mix3_in    = 26'(diff) * 26'($signed({1'b0, weight_eff}));
   end

   // stage four: old plus floored step, stays within 0..255
   always_comb begin
      sum    = 10'(old3_ff) + 10'(mix3_ff[25:16]);
      res_in = sum[7:0];
   end

   always_ff @(posedge clock) begin
      if (stage_ctrl.load[0]) begin
         old1_ff    <= old_value;
         colour1_ff <= colour;
         kind1_ff   <= kind;
         on1_ff     <= lane_on;
         prod1_ff   <= prod1_in;
      end
      if (stage_ctrl.load[1]) begin
         old2_ff  <= old1_ff;
         on2_ff   <= on1_ff;
         tone2_ff <= tone2_in;
      end
      if (stage_ctrl.load[2]) begin
         old3_ff <= old2_ff;
         mix3_ff <= mix3_in;
      end
      if (stage_ctrl.load[3]) begin
         res_ff <= res_in;
      end
   end

   assign new_value = res_ff;

endmodule
`default_nettype wire

// ----- rtl/brush_pixel_blend_top.sv -----
// brush_pixel_blend_top: stamp coverage blend of one pixel per word, four-stage pipeline
// a request word accepted into stage one moves on through stages two and three and is held
// in the stage four output register until the receiver takes it
// throughput: one word per cycle while results are taken, every stage moves whenever the stage after it can take
// the output register holds a result until taken while earlier stages keep filling
// reset: synchronous, clears all stage valid bits and loads the register defaults
`default_nettype none
module brush_pixel_blend_top (
   input  wire logic  clock,
   input  wire logic  reset,
   bpb_stream_if.sink   req_chan,
   bpb_stream_if.source rsp_chan,
   bpb_stream_if.sink   csr_chan
);

   bpb_pkg::csr_type        csr;
   bpb_pkg::stage_ctrl_type stage_ctrl;
   bpb_pkg::req_word_type   req_word;
   bpb_pkg::rsp_word_type   rsp_word;
   bpb_pkg::tone_kind_type  kind;
   logic [16:0]             weight;
   logic                    changed;
   logic [7:0]              new_c0;
   logic [7:0]              new_c1;
   logic [7:0]              new_c2;
   logic                    colour_on;

   assign req_word  = req_chan.data;
   assign kind      = bpb_pkg::tone_kind(csr);
   assign colour_on = !csr.single_channel;

   // register file
   bpb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .csr      (csr)
   );

   // pipeline flow control
   bpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .stage_ctrl (stage_ctrl)
   );

   // blend weight
   bpb_weight u_weight (
      .clock      (clock),
      .stage_ctrl (stage_ctrl),
      .coverage   (req_word.coverage),
      .alpha_q8   (csr.alpha_q8),
      .weight     (weight),
      .changed    (changed)
   );

   // blue or gray lane
   bpb_lane u_lane0 (
      .clock      (clock),
      .stage_ctrl (stage_ctrl),
      .old_value  (req_word.old_c0),
      .colour     (csr.paint_blue),
      .kind       (kind),
      .lane_on    (1'b1),
      .weight     (weight),
      .new_value  (new_c0)
   );

   // green lane, passed through for grayscale
   bpb_lane u_lane1 (
      .clock      (clock),
      .stage_ctrl (stage_ctrl),
      .old_value  (req_word.old_c1),
      .colour     (csr.paint_green),
      .kind       (kind),
      .lane_on    (colour_on),
      .weight     (weight),
      .new_value  (new_c1)
   );

   // red lane, passed through for grayscale
   bpb_lane u_lane2 (
      .clock      (clock),
      .stage_ctrl (stage_ctrl),
      .old_value  (req_word.old_c2),
      .colour     (csr.paint_red),
      .kind       (kind),
      .lane_on    (colour_on),
      .weight     (weight),
      .new_value  (new_c2)
   );

   // result word
   always_comb begin
      rsp_word.new_c0  = new_c0;
      rsp_word.new_c1  = new_c1;
      rsp_word.new_c2  = new_c2;
      rsp_word.changed = changed;
   end

   assign rsp_chan.data = rsp_word;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for the brush pixel blend, directed table then random phases
`timescale 1ns / 100ps
module tb_top;

   // codes not named in the package
   localparam logic [1:0] TOOL_PAINT_ALT   = 2'd3;
   localparam logic [1:0] BLEND_NORMAL_ALT = 2'd3;

   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_PIXELS  = 75;
   localparam int SETTLE_CYCLES = 12;
   localparam int REPORT_LIMIT  = 10;

   typedef enum {STALL_NONE, STALL_PERIODIC, STALL_RANDOM, STALL_RUNS} stall_style_type;

   // one row of the directed table
   typedef struct {
      bit                    reconfig;
      bpb_pkg::csr_type      cfg;
      bpb_pkg::req_word_type px;
      bit                    typed;
      bpb_pkg::rsp_word_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpb_stream_if #(.word_type(bpb_pkg::req_word_type)) req_if ();
   bpb_stream_if #(.word_type(bpb_pkg::rsp_word_type)) rsp_if ();
   bpb_stream_if #(.word_type(bpb_pkg::csr_word_type)) csr_if ();

   brush_pixel_blend_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   bpb_pkg::csr_type      active_cfg;
   bpb_pkg::rsp_word_type expected_pixels [$];
   stim_row_type          stim_table [$];
   int                    error_count     = 0;
   int                    pixels_sent     = 0;
   int                    results_checked = 0;
   int                    settings_loaded = 0;
   int                    zero_cov_count  = 0;
   int                    full_cov_count  = 0;
   int                    idle_cycles     = 0;
   int                    stall_left      = 0;
   int                    style_left      = 0;
   logic [7:0]            beat            = 8'd0;
   stall_style_type       stall_style     = STALL_NONE;

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // expected pixel from the register settings and one request word
   function automatic bpb_pkg::rsp_word_type blend_pixel(input bpb_pkg::csr_type cfg,
                                                         input bpb_pkg::req_word_type px);
      int unsigned           strength;
      int unsigned           weight;
      int unsigned           lanes;
      int unsigned           tone;
      int unsigned           mixed;
      int unsigned           old_ch [3];
      int unsigned           paint_ch [3];
      int unsigned           new_ch [3];
      int                    i;
      bpb_pkg::rsp_word_type r;
      old_ch[0]   = px.old_c0;
      old_ch[1]   = px.old_c1;
      old_ch[2]   = px.old_c2;
      paint_ch[0] = cfg.paint_blue;
      paint_ch[1] = cfg.paint_green;
      paint_ch[2] = cfg.paint_red;
      for (i = 0; i < 3; i++) new_ch[i] = old_ch[i];
      if (px.coverage != 8'd0) begin
         strength = (cfg.alpha_q8 > bpb_pkg::ALPHA_FULL) ? bpb_pkg::ALPHA_FULL : cfg.alpha_q8;
         weight   = (px.coverage * strength * 256) / 255;
         lanes    = cfg.single_channel ? 1 : 3;
         for (i = 0; i < lanes; i++) begin
            if (cfg.tool_mode == bpb_pkg::TOOL_ERASE) begin
               tone = 0;
            end else if (cfg.tool_mode == bpb_pkg::TOOL_SMUDGE || cfg.single_channel ||
                         !cfg.colour_present) begin
               tone = bpb_pkg::TONE_MAX;
            end else if (cfg.blend_select == bpb_pkg::BLEND_MULTIPLY) begin
               tone = (old_ch[i] * paint_ch[i]) / 255;
            end else if (cfg.blend_select == bpb_pkg::BLEND_SCREEN) begin
               tone = 255 - ((255 - old_ch[i]) * (255 - paint_ch[i])) / 255;
            end else begin
               tone = paint_ch[i];
            end
            mixed     = (old_ch[i] * (65536 - weight) + tone * weight) >> 16;
            new_ch[i] = (mixed > 255) ? 255 : mixed;
         end
      end
      r.new_c0  = 8'(new_ch[0]);
      r.new_c1  = 8'(new_ch[1]);
      r.new_c2  = 8'(new_ch[2]);
      r.changed = (px.coverage != 8'd0);
      return r;
   endfunction

   function automatic bpb_pkg::csr_type make_cfg(input logic [8:0] alpha, input logic [7:0] red,
                                                 input logic [7:0] green, input logic [7:0] blue,
                                                 input logic present, input logic [1:0] tool,
                                                 input logic [1:0] blend, input logic single);
      bpb_pkg::csr_type c;
      c.alpha_q8       = alpha;
      c.paint_red      = red;
      c.paint_green    = green;
      c.paint_blue     = blue;
      c.colour_present = present;
      c.tool_mode      = tool;
      c.blend_select   = blend;
      c.single_channel = single;
      return c;
   endfunction

   // level biased toward the two extremes
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // unused upper bits of the write data filled with junk when noisy
   function automatic logic [8:0] with_junk(input logic [8:0] field, input int width,
                                            input bit noisy);
      logic [8:0] junk;
      junk = noisy ? 9'($urandom) : 9'd0;
      return (junk & (9'h1ff << width)) | field;
   endfunction

   task automatic add_row(input bit reconfig, input bpb_pkg::csr_type cfg,
                          input logic [7:0] cov,
                          input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
                          input bit typed, input logic [7:0] e0, input logic [7:0] e1,
                          input logic [7:0] e2, input logic ech);
      stim_row_type row;
      row.reconfig = reconfig;
      row.cfg      = cfg;
      row.px       = '{coverage: cov, old_c0: c0, old_c1: c1, old_c2: c2};
      row.typed    = typed;
      row.want     = '{new_c0: e0, new_c1: e1, new_c2: e2, changed: ech};
      stim_table.push_back(row);
   endtask

   // one register word, shadow copy updated at the handshake
   task automatic write_reg(input bpb_pkg::reg_index_type idx, input logic [8:0] v);
      csr_if.valid <= 1'b1;
      csr_if.data  <= '{index: idx, value: v};
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         bpb_pkg::REG_ALPHA_Q8:       active_cfg.alpha_q8       = v;
         bpb_pkg::REG_PAINT_RED:      active_cfg.paint_red      = v[7:0];
         bpb_pkg::REG_PAINT_GREEN:    active_cfg.paint_green    = v[7:0];
         bpb_pkg::REG_PAINT_BLUE:     active_cfg.paint_blue     = v[7:0];
         bpb_pkg::REG_COLOUR_PRESENT: active_cfg.colour_present = v[0];
         bpb_pkg::REG_TOOL_MODE:      active_cfg.tool_mode      = v[1:0];
         bpb_pkg::REG_BLEND_SELECT:   active_cfg.blend_select   = v[1:0];
         bpb_pkg::REG_SINGLE_CHANNEL: active_cfg.single_channel = v[0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input bpb_pkg::csr_type c, input bit noisy);
      write_reg(bpb_pkg::REG_ALPHA_Q8,       with_junk(9'(c.alpha_q8), 9, noisy));
      write_reg(bpb_pkg::REG_PAINT_RED,      with_junk(9'(c.paint_red), 8, noisy));
      write_reg(bpb_pkg::REG_PAINT_GREEN,    with_junk(9'(c.paint_green), 8, noisy));
      write_reg(bpb_pkg::REG_PAINT_BLUE,     with_junk(9'(c.paint_blue), 8, noisy));
      write_reg(bpb_pkg::REG_COLOUR_PRESENT, with_junk(9'(c.colour_present), 1, noisy));
      write_reg(bpb_pkg::REG_TOOL_MODE,      with_junk(9'(c.tool_mode), 2, noisy));
      write_reg(bpb_pkg::REG_BLEND_SELECT,   with_junk(9'(c.blend_select), 2, noisy));
      write_reg(bpb_pkg::REG_SINGLE_CHANNEL, with_junk(9'(c.single_channel), 1, noisy));
      csr_if.valid <= 1'b0;
      settings_loaded++;
   endtask

   // one pixel word, expectation queued when it is taken
   task automatic send_pixel(input bpb_pkg::req_word_type px, input bpb_pkg::rsp_word_type want);
      req_if.valid <= 1'b1;
      req_if.data  <= px;
      do @(posedge clock); while (!req_if.ready);
      expected_pixels.push_back(want);
      pixels_sent++;
      if (px.coverage == 8'd0) zero_cov_count++;
      if (px.coverage == 8'd255) full_cov_count++;
   endtask

   // waits for a clock edge, then until no expected results are pending
   task automatic pause_until_drained();
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // idle watchdog
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // receiver stall pattern and result check
   always @(posedge clock) begin : result_check
      bpb_pkg::rsp_word_type want;
      beat <= beat + 8'd1;
      if (style_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         style_left  <= $urandom_range(40, 300);
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         STALL_NONE:     rsp_if.ready <= 1'b1;
         STALL_PERIODIC: rsp_if.ready <= (beat[1:0] != 2'd3);
         STALL_RANDOM:   rsp_if.ready <= ($urandom_range(0, 9) > 3);
         default: begin
            if (stall_left != 0) begin
               rsp_if.ready <= 1'b0;
               stall_left   <= stall_left - 1;
            end else begin
               rsp_if.ready <= 1'b1;
               if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(2, 12);
            end
         end
      endcase
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result %0d/%0d/%0d changed %0b with nothing pending",
                        rsp_if.data.new_c0, rsp_if.data.new_c1, rsp_if.data.new_c2,
                        rsp_if.data.changed);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_if.data.new_c0 !== want.new_c0 || rsp_if.data.new_c1 !== want.new_c1 ||
                rsp_if.data.new_c2 !== want.new_c2 || rsp_if.data.changed !== want.changed) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("pixel %0d: want %0d/%0d/%0d chg %0b, got %0d/%0d/%0d chg %0b",
                           results_checked, want.new_c0, want.new_c1, want.new_c2,
                           want.changed, rsp_if.data.new_c0, rsp_if.data.new_c1,
                           rsp_if.data.new_c2, rsp_if.data.changed);
            end
         end
         results_checked++;
      end
   end

   // stimulus
   initial begin : stimulus
      bpb_pkg::csr_type      rnd_cfg;
      bpb_pkg::req_word_type px;
      bpb_pkg::rsp_word_type want;
      int                    phase;
      int                    n;
      int                    burst_left;
      int                    gap;
      bit                    quiet;

      req_if.valid = 1'b0;
      req_if.data  = '0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      active_cfg   = make_cfg(bpb_pkg::ALPHA_FULL, 8'd0, 8'd0, 8'd0, 1'b1, bpb_pkg::TOOL_PAINT,
                              bpb_pkg::BLEND_NORMAL, 1'b0);

      // directed table: reset settings first, then the named special cases
      add_row(0, '0, 8'd0, 8'd12, 8'd34, 8'd56, 1, 8'd12, 8'd34, 8'd56, 0);
      add_row(0, '0, 8'd255, 8'd255, 8'd255, 8'd255, 1, 8'd0, 8'd0, 8'd0, 1);
      add_row(0, '0, 8'd1, 8'd200, 8'd100, 8'd50, 0, 8'd0, 8'd0, 8'd0, 0);
      add_row(1, make_cfg(9'd256, 8'd0, 8'd0, 8'd0, 1, bpb_pkg::TOOL_ERASE,
                          bpb_pkg::BLEND_NORMAL, 0),
              8'd255, 8'd255, 8'd128, 8'd1, 1, 8'd0, 8'd0, 8'd0, 1);
      add_row(0, '0, 8'd130, 8'd255, 8'd128, 8'd1, 0, 8'd0, 8'd0, 8'd0, 0);
      add_row(1, make_cfg(9'd256, 8'd9, 8'd9, 8'd9, 0, bpb_pkg::TOOL_PAINT,
                          bpb_pkg::BLEND_MULTIPLY, 0),
              8'd255, 8'd0, 8'd7, 8'd9, 1, 8'd255, 8'd255, 8'd255, 1);
      add_row(1, make_cfg(9'd256, 8'd10, 8'd20, 8'd30, 1, bpb_pkg::TOOL_SMUDGE,
                          bpb_pkg::BLEND_SCREEN, 0),
              8'd255, 8'd0, 8'd0, 8'd0, 1, 8'd255, 8'd255, 8'd255, 1);
      add_row(1, make_cfg(9'd0, 8'd255, 8'd255, 8'd255, 1, bpb_pkg::TOOL_PAINT,
                          bpb_pkg::BLEND_NORMAL, 0),
              8'd255, 8'd5, 8'd6, 8'd7, 1, 8'd5, 8'd6, 8'd7, 1);
      add_row(0, '0, 8'd0, 8'd5, 8'd6, 8'd7, 1, 8'd5, 8'd6, 8'd7, 0);
      add_row(1, make_cfg(9'd511, 8'd255, 8'd0, 8'd128, 1, bpb_pkg::TOOL_PAINT,
                          bpb_pkg::BLEND_NORMAL, 0),
              8'd255, 8'd0, 8'd0, 8'd0, 1, 8'd128, 8'd0, 8'd255, 1);
      add_row(0, '0, 8'd99, 8'd255, 8'd255, 8'd0, 0, 8'd0, 8'd0, 8'd0, 0);
      add_row(1, make_cfg(9'd256, 8'd200, 8'd100, 8'd50, 1, bpb_pkg::TOOL_PAINT,
                          bpb_pkg::BLEND_MULTIPLY, 0),
              8'd255, 8'd255, 8'd255, 8'd255, 1, 8'd50, 8'd100, 8'd200, 1);
      add_row(0, '0, 8'd77, 8'd90, 8'd180, 8'd240, 0, 8'd0, 8'd0, 8'd0, 0);
      add_row(1, make_cfg(9'd256, 8'd0, 8'd0, 8'd0, 1, bpb_pkg::TOOL_PAINT,
                          bpb_pkg::BLEND_SCREEN, 0),
              8'd255, 8'd10, 8'd20, 8'd30, 1, 8'd10, 8'd20, 8'd30, 1);
      add_row(1, make_cfg(9'd256, 8'd160, 8'd80, 8'd40, 1, bpb_pkg::TOOL_PAINT,
                          bpb_pkg::BLEND_SCREEN, 0),
              8'd100, 8'd60, 8'd120, 8'd200, 0, 8'd0, 8'd0, 8'd0, 0);
      add_row(1, make_cfg(9'd256, 8'd1, 8'd2, 8'd3, 1, bpb_pkg::TOOL_PAINT,
                          BLEND_NORMAL_ALT, 0),
              8'd255, 8'd250, 8'd250, 8'd250, 1, 8'd3, 8'd2, 8'd1, 1);
      add_row(1, make_cfg(9'd256, 8'd0, 8'd0, 8'd0, 1, bpb_pkg::TOOL_PAINT,
                          bpb_pkg::BLEND_MULTIPLY, 1),
              8'd255, 8'd0, 8'd77, 8'd88, 1, 8'd255, 8'd77, 8'd88, 1);
      add_row(0, '0, 8'd128, 8'd100, 8'd1, 8'd2, 0, 8'd0, 8'd0, 8'd0, 0);
      add_row(1, make_cfg(9'd256, 8'd0, 8'd0, 8'd0, 1, bpb_pkg::TOOL_ERASE,
                          bpb_pkg::BLEND_NORMAL, 1),
              8'd255, 8'd200, 8'd9, 8'd8, 1, 8'd0, 8'd9, 8'd8, 1);
      add_row(1, make_cfg(9'd128, 8'd255, 8'd255, 8'd255, 1, TOOL_PAINT_ALT,
                          bpb_pkg::BLEND_NORMAL, 0),
              8'd200, 8'd0, 8'd0, 8'd0, 0, 8'd0, 8'd0, 8'd0, 0);
      add_row(0, '0, 8'd1, 8'd255, 8'd0, 8'd255, 0, 8'd0, 8'd0, 8'd0, 0);

      // hold reset, then release it
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (stim_table[k]) begin
         if (stim_table[k].reconfig) begin
            req_if.valid <= 1'b0;
            pause_until_drained();
            load_settings(stim_table[k].cfg, 1'b0);
         end
         want = stim_table[k].typed ? stim_table[k].want
                                    : blend_pixel(active_cfg, stim_table[k].px);
         send_pixel(stim_table[k].px, want);
      end

      // random phases, each with fresh settings loaded while idle
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0:       rnd_cfg.alpha_q8 = 9'd0;
            1:       rnd_cfg.alpha_q8 = 9'd1;
            2:       rnd_cfg.alpha_q8 = 9'd255;
            3:       rnd_cfg.alpha_q8 = bpb_pkg::ALPHA_FULL;
            4:       rnd_cfg.alpha_q8 = 9'd257;
            5:       rnd_cfg.alpha_q8 = 9'd511;
            default: rnd_cfg.alpha_q8 = 9'($urandom_range(0, 511));
         endcase
         rnd_cfg.paint_red      = pick_level();
         rnd_cfg.paint_green    = pick_level();
         rnd_cfg.paint_blue     = pick_level();
         rnd_cfg.colour_present = ($urandom_range(0, 4) != 0);
         rnd_cfg.tool_mode      = 2'($urandom_range(0, 3));
         rnd_cfg.blend_select   = 2'($urandom_range(0, 3));
         rnd_cfg.single_channel = ($urandom_range(0, 3) == 0);
         req_if.valid <= 1'b0;
         pause_until_drained();
         load_settings(rnd_cfg, 1'b1);

         quiet      = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(1, 40);
         for (n = 0; n < PHASE_PIXELS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap        = quiet ? 0 : $urandom_range(0, 8);
               if ($urandom_range(0, 11) == 0) begin
                  // hold off until the pipeline has emptied
                  req_if.valid <= 1'b0;
                  pause_until_drained();
               end else if (gap != 0) begin
                  req_if.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            px.coverage = pick_level();
            px.old_c0   = pick_level();
            px.old_c1   = pick_level();
            px.old_c2   = pick_level();
            send_pixel(px, blend_pixel(active_cfg, px));
            burst_left--;
         end
      end
      req_if.valid <= 1'b0;

      // drain and let the pipeline settle
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         error_count += expected_pixels.size();
         $display("%0d expected results never arrived", expected_pixels.size());
      end

      $display("%0d pixels sent, %0d results checked, %0d register settings loaded",
               pixels_sent, results_checked, settings_loaded);
      $display("%0d pixels at zero coverage, %0d at full coverage, %0d mismatches",
               zero_cov_count, full_cov_count, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/bpb_pkg.sv
rtl/bpb_stream_if.sv
rtl/bpb_csr.sv
rtl/bpb_ctrl.sv
rtl/bpb_weight.sv
rtl/bpb_lane.sv
rtl/brush_pixel_blend_top.sv
tb/sv/tb_top.sv
